[rtl/base64_stream_decoder_assert.svh]
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define B64SD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define B64SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/b64sd_pkg.sv]
package b64sd_pkg;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   // Offsets that map a character code onto its sextet value.
   localparam logic [7:0] LOWER_OFFSET = 8'd71;
   localparam logic [7:0] DIGIT_OFFSET = 8'd4;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   typedef enum logic [1:0] {
      CHAR_SKIP,
      CHAR_DATA,
      CHAR_FLUSH
   } char_kind_type;

   typedef struct packed {
      char_kind_type kind;
      logic [5:0]    sextet;
   } char_class_type;

   typedef struct packed {
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [1:0] byte_count;
      logic       final_flush;
   } result_type;

endpackage

[rtl/base64_stream_decoder.sv]
// Base64 stream decoder: takes one character per request beat and returns, on the response
// channel, groups of one to three decoded bytes. Alphabet characters are collected four at a
// time into three bytes; '=' or a beat with end_of_data set flushes a partial group of two or
// three characters as one or two bytes with final_flush set, and any other character is
// skipped. A beat is registered on entry and decoded into the response register once that
// register is empty or its result is being accepted, so a stalled response holds the beat
// back. One beat is accepted every cycle while the response side keeps up; req_stall
// rises only when a registered beat waits behind a stalled response.
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_first,
   output logic [7:0] rsp_byte_second,
   output logic [7:0] rsp_byte_third,
   output logic [1:0] rsp_byte_count,
   output logic       rsp_final_flush
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [7:0]                in_char_ff;
   logic                      in_eod_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   b64sd_pkg::result_type     rsp_data_ff;
   logic                      advance;
   logic                      req_take;
   logic                      res_valid;
   b64sd_pkg::result_type     result;
   b64sd_pkg::char_class_type cls;

   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? res_valid : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_in;
         in_eod_ff  <= req_end_of_data;
      end
      if (advance && res_valid) begin
         rsp_data_ff <= result;
      end
   end

   b64sd_classify u_classify (
      .char_in     (in_char_ff),
      .end_of_data (in_eod_ff),
      .cls         (cls)
   );

   b64sd_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cls       (cls),
      .res_valid (res_valid),
      .result    (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_first  = rsp_data_ff.byte_first;
   assign rsp_byte_second = rsp_data_ff.byte_second;
   assign rsp_byte_third  = rsp_data_ff.byte_third;
   assign rsp_byte_count  = rsp_data_ff.byte_count;
   assign rsp_final_flush = rsp_data_ff.final_flush;

   `B64SD_ASSERT_NOW(a_full_group_not_flush, clock, reset, rsp_valid_ff && !rsp_data_ff.final_flush, rsp_data_ff.byte_count == b64sd_pkg::COUNT_THREE)
   `B64SD_ASSERT_NOW(a_flush_partial, clock, reset, rsp_valid_ff && rsp_data_ff.final_flush, rsp_data_ff.byte_count == b64sd_pkg::COUNT_ONE || rsp_data_ff.byte_count == b64sd_pkg::COUNT_TWO)
   `B64SD_ASSERT_NOW(a_unused_bytes_zero, clock, reset, rsp_valid_ff && rsp_data_ff.byte_count != b64sd_pkg::COUNT_THREE, rsp_data_ff.byte_third == 8'd0)
   `B64SD_ASSERT_NEXT(a_held_beat_kept, clock, reset, in_valid_ff && rsp_valid_ff && rsp_stall, in_valid_ff && rsp_valid_ff)

endmodule

[rtl/b64sd_classify.sv]
module b64sd_classify (
   input  logic [7:0]               char_in,
   input  logic                     end_of_data,
   output b64sd_pkg::char_class_type cls
);

   always_comb begin
      cls.kind   = b64sd_pkg::CHAR_SKIP;
      cls.sextet = 6'd0;
      if (end_of_data || char_in == b64sd_pkg::CHAR_PAD) begin
         cls.kind = b64sd_pkg::CHAR_FLUSH;
      end else if (char_in inside {[b64sd_pkg::CHAR_UPPER_A:b64sd_pkg::CHAR_UPPER_Z]}) begin
         cls.kind   = b64sd_pkg::CHAR_DATA;
         cls.sextet = 6'(char_in - b64sd_pkg::CHAR_UPPER_A);
      end else if (char_in inside {[b64sd_pkg::CHAR_LOWER_A:b64sd_pkg::CHAR_LOWER_Z]}) begin
         cls.kind   = b64sd_pkg::CHAR_DATA;
         cls.sextet = 6'(char_in - b64sd_pkg::LOWER_OFFSET);
      end else if (char_in inside {[b64sd_pkg::CHAR_DIGIT_0:b64sd_pkg::CHAR_DIGIT_9]}) begin
         cls.kind   = b64sd_pkg::CHAR_DATA;
         cls.sextet = 6'(char_in + b64sd_pkg::DIGIT_OFFSET);
      end else if (char_in == b64sd_pkg::CHAR_PLUS) begin
         cls.kind   = b64sd_pkg::CHAR_DATA;
         cls.sextet = b64sd_pkg::SEXTET_PLUS;
      end else if (char_in == b64sd_pkg::CHAR_SLASH) begin
         cls.kind   = b64sd_pkg::CHAR_DATA;
         cls.sextet = b64sd_pkg::SEXTET_SLASH;
      end
   end

endmodule

[rtl/b64sd_assemble.sv]
module b64sd_assemble (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  b64sd_pkg::char_class_type cls,
   output logic                      res_valid,
   output b64sd_pkg::result_type     result
);

   logic [7:0] asm_ff [3];
   logic [7:0] asm_in [3];
   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 2'd0;
         asm_ff[0] <= 8'd0;
         asm_ff[1] <= 8'd0;
         asm_ff[2] <= 8'd0;
      end else if (advance) begin
         pend_ff   <= pend_in;
         asm_ff[0] <= asm_in[0];
         asm_ff[1] <= asm_in[1];
         asm_ff[2] <= asm_in[2];
      end
   end

   always_comb begin
      asm_in    = asm_ff;
      pend_in   = pend_ff;
      res_valid = 1'b0;
      result    = '0;
      case (cls.kind)
         b64sd_pkg::CHAR_FLUSH: begin
            pend_in = 2'd0;
            if (pend_ff == 2'd2) begin
               res_valid          = 1'b1;
               result.byte_first  = asm_ff[0];
               result.byte_count  = b64sd_pkg::COUNT_ONE;
               result.final_flush = 1'b1;
            end else if (pend_ff == 2'd3) begin
               res_valid          = 1'b1;
               result.byte_first  = asm_ff[0];
               result.byte_second = asm_ff[1];
               result.byte_count  = b64sd_pkg::COUNT_TWO;
               result.final_flush = 1'b1;
            end
         end
         b64sd_pkg::CHAR_DATA: begin
            case (pend_ff)
               2'd0: begin
                  asm_in[0] = {cls.sextet, 2'b00};
                  pend_in   = 2'd1;
               end
               2'd1: begin
                  asm_in[0] = asm_ff[0] | {6'd0, cls.sextet[5:4]};
                  asm_in[1] = {cls.sextet[3:0], 4'd0};
                  pend_in   = 2'd2;
               end
               2'd2: begin
                  asm_in[1] = asm_ff[1] | {4'd0, cls.sextet[5:2]};
                  asm_in[2] = {cls.sextet[1:0], 6'd0};
                  pend_in   = 2'd3;
               end
               default: begin
                  asm_in[2]          = asm_ff[2] | {2'd0, cls.sextet};
                  pend_in            = 2'd0;
                  res_valid          = 1'b1;
                  result.byte_first  = asm_ff[0];
                  result.byte_second = asm_ff[1];
                  result.byte_third  = asm_ff[2] | {2'd0, cls.sextet};
                  result.byte_count  = b64sd_pkg::COUNT_THREE;
                  result.final_flush = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

endmodule

[sim/tb_base64_stream_decoder.sv]
`timescale 1ns / 100ps

module tb_base64_stream_decoder;

   localparam int         RANDOM_ITEMS = 420;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         HOLD_CYCLES  = 80;
   localparam int         HOLD_AT_BEAT = 120;
   localparam int         DRAIN_CYCLES = 8;
   localparam logic [6:0] NO_SEXTET    = 7'd64;
   localparam logic [6:0] LOWER_BASE   = 7'd26;
   localparam logic [6:0] DIGIT_BASE   = 7'd52;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_HIGH    = 8'hFF;

   typedef struct packed {
      logic [7:0]            ch;
      logic                  eod;
      logic                  typed;
      logic                  yields;
      b64sd_pkg::result_type res;
   } vector_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_in;
   logic       req_end_of_data;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_byte_first;
   logic [7:0] rsp_byte_second;
   logic [7:0] rsp_byte_third;
   logic [1:0] rsp_byte_count;
   logic       rsp_final_flush;

   logic [7:0]            group_bytes [0:2];
   logic [1:0]            group_fill;
   b64sd_pkg::result_type expected_groups [$];
   vector_row_type        directed [$];
   int                    beats_in;
   int                    groups_out;
   int                    flushes_out;
   int                    mismatches;
   int                    idle_cycles;
   int                    burst_left;

   base64_stream_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_end_of_data (req_end_of_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_first  (rsp_byte_first),
      .rsp_byte_second (rsp_byte_second),
      .rsp_byte_third  (rsp_byte_third),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_final_flush (rsp_final_flush)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [6:0] sextet_value(input logic [7:0] ch);
      if (ch >= b64sd_pkg::CHAR_UPPER_A && ch <= b64sd_pkg::CHAR_UPPER_Z)
         return 7'(ch - b64sd_pkg::CHAR_UPPER_A);
      if (ch >= b64sd_pkg::CHAR_LOWER_A && ch <= b64sd_pkg::CHAR_LOWER_Z)
         return 7'(ch - b64sd_pkg::CHAR_LOWER_A) + LOWER_BASE;
      if (ch >= b64sd_pkg::CHAR_DIGIT_0 && ch <= b64sd_pkg::CHAR_DIGIT_9)
         return 7'(ch - b64sd_pkg::CHAR_DIGIT_0) + DIGIT_BASE;
      if (ch == b64sd_pkg::CHAR_PLUS) return 7'(b64sd_pkg::SEXTET_PLUS);
      if (ch == b64sd_pkg::CHAR_SLASH) return 7'(b64sd_pkg::SEXTET_SLASH);
      return NO_SEXTET;
   endfunction

   function automatic logic [7:0] char_of_sextet(input logic [5:0] v);
      if (v < LOWER_BASE) return b64sd_pkg::CHAR_UPPER_A + 8'(v);
      if (v < DIGIT_BASE) return b64sd_pkg::CHAR_LOWER_A + 8'(v - LOWER_BASE);
      if (v < 7'(b64sd_pkg::SEXTET_PLUS)) return b64sd_pkg::CHAR_DIGIT_0 + 8'(v - DIGIT_BASE);
      if (v == b64sd_pkg::SEXTET_PLUS) return b64sd_pkg::CHAR_PLUS;
      return b64sd_pkg::CHAR_SLASH;
   endfunction

   // Advances the decoder state by one beat; returns 1 when the beat yields a group.
   function automatic logic decode_beat(input logic [7:0] ch, input logic eod,
                                        output b64sd_pkg::result_type res);
      logic [6:0] sx;
      logic [1:0] held;
      res = '0;
      if (eod || ch == b64sd_pkg::CHAR_PAD) begin
         held = group_fill;
         group_fill = 2'd0;
         if (held < b64sd_pkg::COUNT_TWO) return 1'b0;
         res.byte_first  = group_bytes[0];
         res.byte_second = (held == b64sd_pkg::COUNT_THREE) ? group_bytes[1] : 8'h00;
         res.byte_count  = held - b64sd_pkg::COUNT_ONE;
         res.final_flush = 1'b1;
         return 1'b1;
      end
      sx = sextet_value(ch);
      if (sx == NO_SEXTET) return 1'b0;
      case (group_fill)
         2'd0: begin
            group_bytes[0] = {sx[5:0], 2'b00};
            group_fill     = b64sd_pkg::COUNT_ONE;
         end
         b64sd_pkg::COUNT_ONE: begin
            group_bytes[0] = group_bytes[0] | {6'd0, sx[5:4]};
            group_bytes[1] = {sx[3:0], 4'd0};
            group_fill     = b64sd_pkg::COUNT_TWO;
         end
         b64sd_pkg::COUNT_TWO: begin
            group_bytes[1] = group_bytes[1] | {4'd0, sx[5:2]};
            group_bytes[2] = {sx[1:0], 6'd0};
            group_fill     = b64sd_pkg::COUNT_THREE;
         end
         default: begin
            group_bytes[2]  = group_bytes[2] | {2'd0, sx[5:0]};
            group_fill      = 2'd0;
            res.byte_first  = group_bytes[0];
            res.byte_second = group_bytes[1];
            res.byte_third  = group_bytes[2];
            res.byte_count  = b64sd_pkg::COUNT_THREE;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      $display("mismatch in %s at result %0d: got %0h, want %0h", field, groups_out, got, want);
   endtask

   task automatic add_row(input logic [7:0] ch, input logic eod, input logic typed,
                          input logic yields, input logic [7:0] b1, input logic [7:0] b2,
                          input logic [7:0] b3, input logic [1:0] cnt, input logic ff);
      vector_row_type row;
      row.ch     = ch;
      row.eod    = eod;
      row.typed  = typed;
      row.yields = yields;
      row.res    = '{byte_first: b1, byte_second: b2, byte_third: b3,
                     byte_count: cnt, final_flush: ff};
      directed.push_back(row);
   endtask

   task automatic offer_beat(input logic [7:0] ch, input logic eod);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_char_in     <= ch;
      req_end_of_data <= eod;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin : monitor
      b64sd_pkg::result_type want;
      b64sd_pkg::result_type predicted;
      logic                  yields;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_groups.size() == 0) begin
               report_mismatch("unexpected result, byte_count", rsp_byte_count, 0);
            end else begin
               want = expected_groups.pop_front();
               if (rsp_byte_first !== want.byte_first)
                  report_mismatch("byte_first", rsp_byte_first, want.byte_first);
               if (rsp_byte_second !== want.byte_second)
                  report_mismatch("byte_second", rsp_byte_second, want.byte_second);
               if (rsp_byte_third !== want.byte_third)
                  report_mismatch("byte_third", rsp_byte_third, want.byte_third);
               if (rsp_byte_count !== want.byte_count)
                  report_mismatch("byte_count", rsp_byte_count, want.byte_count);
               if (rsp_final_flush !== want.final_flush)
                  report_mismatch("final_flush", rsp_final_flush, want.final_flush);
            end
            groups_out++;
            if (rsp_final_flush) flushes_out++;
         end
         if (req_valid && !req_stall) begin
            yields = decode_beat(req_char_in, req_end_of_data, predicted);
            if (beats_in < directed.size() && directed[beats_in].typed) begin
               yields    = directed[beats_in].yields;
               predicted = directed[beats_in].res;
            end
            if (yields) expected_groups.push_back(predicted);
            beats_in++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver stalls in phases of random length and, once, holds off for a long stretch.
   initial begin
      int  phase_len;
      int  kind;
      logic held_off;
      held_off = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         phase_len = $urandom_range(1, 40);
         kind      = $urandom_range(0, 2);
         repeat (phase_len) begin
            @(posedge clock);
            if (!held_off && beats_in >= HOLD_AT_BEAT) begin
               held_off = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (kind)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   initial begin
      int         counted;
      int         pick;
      logic [7:0] ch;
      logic       eod;
      group_bytes[0] = 8'h00;
      group_bytes[1] = 8'h00;
      group_bytes[2] = 8'h00;
      group_fill     = 2'd0;
      beats_in       = 0;
      groups_out     = 0;
      flushes_out    = 0;
      mismatches     = 0;
      idle_cycles    = 0;
      burst_left     = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_char_in     <= 8'h00;
      req_end_of_data <= 1'b0;

      add_row("T", 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("W", 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("F", 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("u", 1'b0, 1'b1, 1'b1, 8'h4D, 8'h61, 8'h6E, b64sd_pkg::COUNT_THREE, 1'b0);
      repeat (3) add_row("A", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("A", 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, b64sd_pkg::COUNT_THREE, 1'b0);
      repeat (3) add_row("/", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("/", 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, b64sd_pkg::COUNT_THREE, 1'b0);
      add_row("0", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("9", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("a", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("z", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("T", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("W", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row(b64sd_pkg::CHAR_PAD, 1'b0, 1'b1, 1'b1, 8'h4D, 8'h00, 8'h00,
              b64sd_pkg::COUNT_ONE, 1'b1);
      add_row(b64sd_pkg::CHAR_PAD, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("T", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("W", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("F", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("A", 1'b1, 1'b1, 1'b1, 8'h4D, 8'h61, 8'h00, b64sd_pkg::COUNT_TWO, 1'b1);
      add_row(CHAR_SPACE, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row(CHAR_HIGH, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row("+", 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);
      add_row(8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) offer_beat(directed[i].ch, directed[i].eod);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         eod  = 1'b0;
         if (pick < 68) begin
            ch = char_of_sextet(6'($urandom_range(0, 63)));
         end else if (pick < 76) begin
            ch = b64sd_pkg::CHAR_PAD;
         end else if (pick < 82) begin
            ch  = 8'($urandom_range(0, 255));
            eod = 1'b1;
         end else if (pick < 90) begin
            case ($urandom_range(0, 3))
               0:       ch = CHAR_SPACE;
               1:       ch = CHAR_TAB;
               2:       ch = CHAR_LF;
               default: ch = CHAR_CR;
            endcase
         end else begin
            ch = 8'($urandom_range(0, 255));
         end
         offer_beat(ch, eod);
         counted++;
      end
      req_valid <= 1'b0;

      while (expected_groups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d character beats (%0d directed), received %0d byte groups, %0d flushes",
               beats_in, directed.size(), groups_out, flushes_out);
      $display("random stalls on both sides plus one long response hold-off; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
